>>> sv/source_text_tokenizer_assert.svh
// Assertion macros for the tokenizer. Each expects clk and rst_n in scope.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STT_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tokenizer assertion failed");
`define STT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");
`else
`define STT_ASSERT(lbl, expr)
`define STT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/stt_pkg.sv
package stt_pkg;

    localparam int KW_MAX_LEN = 8;
    localparam int KW_IDX_W   = $clog2(KW_MAX_LEN);
    localparam int KW_COUNT   = 28;
    localparam int BRACE_MAX  = 255;

    localparam logic [5:0] K_STAR    = 6'd2;
    localparam logic [5:0] K_STAR_EQ = 6'd3;
    localparam logic [5:0] K_MOD_EQ  = 6'd5;
    localparam logic [5:0] K_DIV_EQ  = 6'd8;
    localparam logic [5:0] K_EQ_EQ   = 6'd12;
    localparam logic [5:0] K_NOT_EQ  = 6'd14;
    localparam logic [5:0] K_GT_EQ   = 6'd16;
    localparam logic [5:0] K_LT_EQ   = 6'd18;
    localparam logic [5:0] K_AND_AND = 6'd19;
    localparam logic [5:0] K_OR_OR   = 6'd21;
    localparam logic [5:0] K_STRING  = 6'd31;
    localparam logic [5:0] K_NUMBER  = 6'd32;
    localparam logic [5:0] K_IDENT   = 6'd33;
    localparam logic [5:0] K_FIRST_KW = 6'd34;
    localparam logic [5:0] K_CPP     = 6'd47;
    localparam logic [5:0] K_ERROR   = 6'd62;
    localparam logic [5:0] K_END     = 6'd63;

    // Sentinels returned by the operator lookups
    localparam logic [5:0] PAIR_NONE    = K_ERROR;
    localparam logic [5:0] PAIR_COMMENT = K_END;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [19:0] OFF_MAX  = 20'hFFFFF;
    localparam logic [19:0] LINE_MAX = 20'hFFFFF;
    localparam logic [15:0] COL_MAX  = 16'hFFFF;
    localparam logic [15:0] SPAN_MAX = 16'hFFFF;

    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        64'("fn"), 64'("continue"), 64'("break"), 64'("let"),
        64'("true"), 64'("false"), 64'("if"), 64'("else"),
        64'("return"), 64'("for"), 64'("struct"), 64'("null"),
        64'("extern"), 64'("cpp"), 64'("i8"), 64'("i16"),
        64'("i32"), 64'("i64"), 64'("u8"), 64'("u16"),
        64'("u32"), 64'("u64"), 64'("f32"), 64'("f64"),
        64'("char"), 64'("bool"), 64'("str"), 64'("void")
    };
    localparam int KW_LEN [KW_COUNT] = '{
        2, 8, 5, 3, 4, 5, 2, 4, 6, 3, 6, 4, 6, 3,
        2, 3, 3, 3, 2, 3, 3, 3, 3, 3, 4, 4, 3, 4
    };

    typedef struct packed {
        logic [19:0] off;
        logic [19:0] line;
        logic [15:0] col;
    } pos_t;

    typedef struct packed {
        logic [5:0]  kind;
        pos_t        pos;
        logic [15:0] len;
    } token_t;

    typedef struct packed {
        token_t [2:0] tok;
        logic [1:0]   cnt;
    } bundle_t;

    typedef struct packed {
        logic    push;
        bundle_t data;
    } q_wr_t;

    function automatic token_t mk_tok(input logic [5:0] kind, input pos_t p,
                                      input logic [15:0] len);
        token_t t;
        t.kind = kind;
        t.pos  = p;
        t.len  = len;
        return t;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_num_byte(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46) ||
               c == 8'h5F || c == CH_DOT || c == 8'h78 || c == 8'h58 ||
               c == 8'h6F || c == 8'h4F;
    endfunction

    // Lone operator kind, K_ERROR when the byte is no operator
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            8'h2B:   k = 6'd0;
            8'h2D:   k = 6'd1;
            8'h2A:   k = 6'd2;
            8'h25:   k = 6'd4;
            8'h5C:   k = 6'd6;
            8'h2F:   k = 6'd7;
            8'h28:   k = 6'd9;
            8'h29:   k = 6'd10;
            8'h3D:   k = 6'd11;
            8'h21:   k = 6'd13;
            8'h3E:   k = 6'd15;
            8'h3C:   k = 6'd17;
            8'h26:   k = 6'd20;
            8'h7C:   k = 6'd22;
            8'h7E:   k = 6'd23;
            8'h5E:   k = 6'd24;
            8'h2C:   k = 6'd25;
            8'h2E:   k = 6'd26;
            8'h3B:   k = 6'd27;
            8'h3A:   k = 6'd28;
            8'h7B:   k = 6'd29;
            8'h7D:   k = 6'd30;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic pairable(input logic [7:0] c);
        return c == 8'h2A || c == 8'h25 || c == 8'h2F || c == 8'h3D || c == 8'h21 ||
               c == 8'h3E || c == 8'h3C || c == 8'h26 || c == 8'h7C;
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic [7:0] n);
        logic [5:0] k;
        k = PAIR_NONE;
        if (h == CH_STAR && n == CH_STAR) k = K_STAR;
        else if (h == CH_SLASH && n == CH_SLASH) k = PAIR_COMMENT;
        else if (h == CH_AMP) k = (n == CH_AMP) ? K_AND_AND : PAIR_NONE;
        else if (h == CH_BAR) k = (n == CH_BAR) ? K_OR_OR : PAIR_NONE;
        else if (n == CH_EQ) begin
            case (h)
                8'h2A:   k = K_STAR_EQ;
                8'h25:   k = K_MOD_EQ;
                8'h2F:   k = K_DIV_EQ;
                8'h3D:   k = K_EQ_EQ;
                8'h21:   k = K_NOT_EQ;
                8'h3E:   k = K_GT_EQ;
                8'h3C:   k = K_LT_EQ;
                default: k = PAIR_NONE;
            endcase
        end
        return k;
    endfunction

    // Parallel compare of the word buffer against every keyword
    function automatic logic [5:0] kw_kind(input logic [KW_MAX_LEN-1:0][7:0] wb,
                                           input logic [15:0] len, input logic too_long);
        logic [5:0] k;
        logic       same;
        int         sel;
        k = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            same = !too_long && (len == 16'(KW_LEN[i]));
            for (int j = 0; j < KW_MAX_LEN; j++) begin
                sel = (KW_LEN[i] > j) ? (KW_LEN[i] - 1 - j) : 0;
                if (KW_LEN[i] > j && wb[j] != KW_TEXT[i][8*sel +: 8]) same = 1'b0;
            end
            if (same) k = K_FIRST_KW + 6'(i);
        end
        return k;
    endfunction

endpackage

>>> sv/stt_queue.sv
`include "source_text_tokenizer_assert.svh"

module stt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  stt_pkg::q_wr_t   wr,
    input  logic             pop,
    output stt_pkg::bundle_t head,
    output logic             empty,
    output logic             full
);
    import stt_pkg::*;

    bundle_t    mem_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    assign empty = (count_reg == 3'd0);
    assign full  = (count_reg == 3'd4);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr.push) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + {2'd0, wr.push} - {2'd0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push) mem_reg[wr_ptr_reg] <= wr.data;
    end

    `STT_ASSERT(q_no_overflow, !(wr.push && full))
    `STT_ASSERT(q_no_underflow, !(pop && empty))
    `STT_ASSERT_NEXT(q_count_grows, wr.push && !pop, count_reg == $past(count_reg) + 3'd1)

endmodule

>>> sv/stt_front.sv
module stt_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     ch,
    input  logic           end_of_text,
    output stt_pkg::q_wr_t wr
);
    import stt_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_HELD, M_COMMENT, M_STRING, M_WORD, M_NUMBER, M_CPP
    } mode_t;

    mode_t                        mode_reg, mode_next;
    logic [7:0]                   held_reg, held_next;
    logic [KW_MAX_LEN-1:0][7:0]   wbuf_reg, wbuf_next;
    logic                         long_reg, long_next;
    logic [1:0]                   pts_reg, pts_next, pts_inc;
    logic [7:0]                   depth_reg, depth_next, depth_v;
    logic [15:0]                  span_reg, span_next, span_inc;
    pos_t                         pos_reg, pos_next, org_reg, org_next;
    token_t [2:0]                 toks;
    logic [1:0]                   n;
    logic                         relex;
    logic [5:0]                   pk, kw_now, kw_flush;

    always_comb
    begin
        mode_next  = mode_reg;
        held_next  = held_reg;
        wbuf_next  = wbuf_reg;
        long_next  = long_reg;
        pts_next   = pts_reg;
        depth_next = depth_reg;
        span_next  = span_reg;
        org_next   = org_reg;
        toks       = '0;
        n          = 2'd0;
        relex      = 1'b0;
        pk         = pair_kind(held_reg, ch);
        kw_now     = kw_kind(wbuf_reg, span_reg, long_reg);
        span_inc   = (span_reg == SPAN_MAX) ? span_reg : span_reg + 16'd1;
        pts_inc    = (pts_reg == 2'd3) ? pts_reg : pts_reg + 2'd1;
        depth_v    = depth_reg;

        // Advance position once per byte
        pos_next.off  = (pos_reg.off < OFF_MAX) ? pos_reg.off + 20'd1 : pos_reg.off;
        pos_next.line = pos_reg.line;
        pos_next.col  = (pos_reg.col < COL_MAX) ? pos_reg.col + 16'd1 : pos_reg.col;
        if (ch == CH_LF)
        begin
            pos_next.line = (pos_reg.line < LINE_MAX) ? pos_reg.line + 20'd1 : pos_reg.line;
            pos_next.col  = '0;
        end

        case (mode_reg)
            M_HELD:
            begin
                mode_next = M_IDLE;
                if (pk == PAIR_COMMENT)
                    mode_next = M_COMMENT;
                else if (pk != PAIR_NONE)
                begin
                    toks[n] = mk_tok(pk, org_reg, '0);
                    n = n + 2'd1;
                end
                else
                begin
                    toks[n] = mk_tok(single_kind(held_reg), org_reg, '0);
                    n = n + 2'd1;
                    relex = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (ch == CH_LF) mode_next = M_IDLE;
            end
            M_STRING:
            begin
                if (ch == CH_QUOTE || ch == CH_LF)
                begin
                    toks[n] = mk_tok(K_STRING, org_reg, span_reg);
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                end
                else
                    span_next = span_inc;
            end
            M_WORD:
            begin
                if (is_alpha(ch) || is_digit(ch))
                begin
                    if (span_reg < 16'(KW_MAX_LEN))
                        wbuf_next[span_reg[KW_IDX_W-1:0]] = ch;
                    else
                        long_next = 1'b1;
                    span_next = span_inc;
                end
                else if (kw_now == K_CPP)
                begin
                    mode_next  = M_CPP;
                    depth_next = 8'd1;
                    span_next  = '0;
                end
                else
                begin
                    toks[n] = mk_tok(kw_now, org_reg, span_reg);
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                    relex = 1'b1;
                end
            end
            M_NUMBER:
            begin
                if (is_num_byte(ch))
                begin
                    span_next = span_inc;
                    if (ch == CH_DOT)
                    begin
                        pts_next = pts_inc;
                        if (pts_inc > 2'd1)
                        begin
                            toks[n] = mk_tok(K_NUMBER, org_reg, span_inc);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                        end
                    end
                end
                else
                begin
                    toks[n] = mk_tok(K_NUMBER, org_reg, span_reg);
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                    relex = 1'b1;
                end
            end
            M_CPP:
            begin
                span_next = span_inc;
                if (ch == CH_LBRACE)
                begin
                    if (depth_v < 8'(BRACE_MAX)) depth_v = depth_v + 8'd1;
                end
                else if (ch == CH_RBRACE)
                begin
                    if (depth_v > 8'd0) depth_v = depth_v - 8'd1;
                    if (depth_v == 8'd1) depth_v = 8'd0;
                end
                depth_next = depth_v;
                if (depth_v == 8'd0)
                begin
                    toks[n] = mk_tok(K_CPP, org_reg, span_inc);
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                end
            end
            default: ;
        endcase

        // Start of a new token, either from idle or when this byte ended a token without being part of it
        if (mode_reg == M_IDLE || relex)
        begin
            mode_next = M_IDLE;
            org_next  = pos_reg;
            if (is_space(ch))
            begin
            end
            else if (pairable(ch))
            begin
                held_next = ch;
                mode_next = M_HELD;
            end
            else if (single_kind(ch) != K_ERROR)
            begin
                toks[n] = mk_tok(single_kind(ch), pos_reg, '0);
                n = n + 2'd1;
            end
            else if (ch == CH_QUOTE)
            begin
                span_next = '0;
                mode_next = M_STRING;
            end
            else if (is_alpha(ch))
            begin
                wbuf_next[0] = ch;
                span_next    = 16'd1;
                long_next    = 1'b0;
                mode_next    = M_WORD;
            end
            else if (is_digit(ch))
            begin
                span_next = 16'd1;
                pts_next  = 2'd0;
                mode_next = M_NUMBER;
            end
            else
            begin
                toks[n] = mk_tok(K_ERROR, pos_reg, '0);
                n = n + 2'd1;
            end
        end

        kw_flush = kw_kind(wbuf_next, span_next, long_next);

        if (end_of_text)
        begin
            // Flush whatever is open, then close the text
            case (mode_next)
                M_HELD:   begin toks[n] = mk_tok(single_kind(held_next), org_next, '0);
                                n = n + 2'd1; end
                M_STRING: begin toks[n] = mk_tok(K_STRING, org_next, span_next);
                                n = n + 2'd1; end
                M_WORD:   begin toks[n] = mk_tok(kw_flush, org_next,
                                              (kw_flush == K_CPP) ? 16'd0 : span_next);
                                n = n + 2'd1; end
                M_NUMBER: begin toks[n] = mk_tok(K_NUMBER, org_next, span_next);
                                n = n + 2'd1; end
                M_CPP:    begin toks[n] = mk_tok(K_CPP, org_next, span_next);
                                n = n + 2'd1; end
                default: ;
            endcase
            if (n != 2'd3)
            begin
                toks[n] = mk_tok(K_END, '{off: pos_next.off, line: '0, col: '0}, '0);
                n = n + 2'd1;
            end
            mode_next     = M_IDLE;
            held_next     = '0;
            long_next     = 1'b0;
            pts_next      = '0;
            depth_next    = '0;
            span_next     = '0;
            org_next      = '0;
            pos_next.off  = '0;
            pos_next.line = 20'd1;
            pos_next.col  = '0;
        end
    end

    assign wr.push     = accept && (n != 2'd0);
    assign wr.data.tok = toks;
    assign wr.data.cnt = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            held_reg     <= '0;
            long_reg     <= 1'b0;
            pts_reg      <= '0;
            depth_reg    <= '0;
            span_reg     <= '0;
            org_reg      <= '0;
            pos_reg.off  <= '0;
            pos_reg.line <= 20'd1;
            pos_reg.col  <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            long_reg  <= long_next;
            pts_reg   <= pts_next;
            depth_reg <= depth_next;
            span_reg  <= span_next;
            org_reg   <= org_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) wbuf_reg <= wbuf_next;
    end

endmodule

>>> sv/stt_back.sv
module stt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  stt_pkg::bundle_t head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output stt_pkg::token_t  out_tok,
    output logic             out_last
);
    import stt_pkg::*;

    bundle_t    cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next, src_idx, src_cnt;
    logic       busy_reg, busy_next;
    logic       valid_reg, valid_next;
    token_t     tok_reg, src_tok;
    logic       last_reg, last;
    logic       load, have;

    assign load    = !valid_reg || !out_stall;
    assign have    = busy_reg || !empty;
    assign src_tok = busy_reg ? cur_reg.tok[idx_reg] : head.tok[0];
    assign src_cnt = busy_reg ? cur_reg.cnt : head.cnt;
    assign src_idx = busy_reg ? idx_reg : 2'd0;
    assign last    = (src_idx + 2'd1 == src_cnt);

    always_comb
    begin
        pop        = 1'b0;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = have;
            if (have && !busy_reg)
            begin
                pop = 1'b1;
                if (!last)
                begin
                    cur_next  = head;
                    idx_next  = 2'd1;
                    busy_next = 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (last) busy_next = 1'b0;
                else idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (load && have)
        begin
            tok_reg  <= src_tok;
            last_reg <= last;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;
    assign out_last  = last_reg;

endmodule

>>> sv/source_text_tokenizer.sv
// Streaming tokenizer: source text goes in one byte per beat, tokens come out
// one per beat.
// Input channel: in_valid/in_stall with ch and end_of_text. Mark the final
// byte of a text with end_of_text; any open token is flushed and an end token
// follows unless the byte gave three; a new text starts at offset 0, line 1.
// Output channel: out_valid/out_stall with the token fields; last_of_run marks
// the final token caused by one input byte (a byte causes zero to three).
// Throughput: one byte per cycle while each byte causes at most one token and
// the receiver does not stall; the tokens of a byte that causes more leave one
// per beat. The front end registers the lexer state for each accepted byte.
// A token is registered in the bundle queue and then in the output register.
// A four-entry bundle queue separates front from back. When the receiver
// stalls, the queue fills and in_stall rises once it is full; nothing is
// dropped. Reset clears lexer state, the queue and the output valid flag.
module source_text_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [19:0] start_offset,
    output logic [19:0] start_line,
    output logic [15:0] start_column,
    output logic [15:0] span_length,
    output logic        last_of_run
);
    import stt_pkg::*;

    q_wr_t   wr;
    bundle_t head;
    logic    empty, full, pop, accept;
    token_t  tok;

    // Hold the input whenever the queue has no free entry
    assign in_stall = full;
    assign accept   = in_valid && !full;

    stt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .ch          (ch),
        .end_of_text (end_of_text),
        .wr          (wr)
    );

    stt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .pop   (pop),
        .head  (head),
        .empty (empty),
        .full  (full)
    );

    stt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_tok   (tok),
        .out_last  (last_of_run)
    );

    assign token_kind   = tok.kind;
    assign start_offset = tok.pos.off;
    assign start_line   = tok.pos.line;
    assign start_column = tok.pos.col;
    assign span_length  = tok.len;

endmodule

>>> tb/source_text_tokenizer_test.sv
`timescale 1ns / 1ps

module source_text_tokenizer_test;
    import stt_pkg::*;

    // Scanner modes of the predictor
    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_HELD, SCAN_COMMENT, SCAN_STRING, SCAN_WORD, SCAN_NUMBER, SCAN_CPP
    } scan_t;

    localparam int STALL_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  ch;
    logic        end_of_text;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  token_kind;
    logic [19:0] start_offset;
    logic [19:0] start_line;
    logic [15:0] start_column;
    logic [15:0] span_length;
    logic        last_of_run;

    source_text_tokenizer uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .ch(ch), .end_of_text(end_of_text),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .start_offset(start_offset), .start_line(start_line),
        .start_column(start_column), .span_length(span_length), .last_of_run(last_of_run)
    );

    typedef struct {
        logic [5:0]  kind;
        logic [19:0] off;
        logic [19:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic        last;
    } token_rec_t;

    // Tokens still owed by the block, oldest first
    token_rec_t pending_tokens[$];

    // Lexer state mirrored by the predictor
    scan_t       lx_mode;
    logic [7:0]  lx_held;
    logic [7:0]  lx_word [8];
    logic        lx_too_long;
    logic [1:0]  lx_points;
    logic [7:0]  lx_depth;
    logic [19:0] lx_off;
    logic [19:0] lx_line;
    logic [15:0] lx_col;
    logic [19:0] org_off;
    logic [19:0] org_line;
    logic [15:0] org_col;
    logic [15:0] lx_span;
    token_rec_t  step_tokens[$];

    int  cycle_count;
    int  mismatch_count;
    int  tokens_seen;
    int  bytes_sent;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_receiver;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void lexer_clear();
        lx_mode = SCAN_IDLE;
        lx_held = '0;
        foreach (lx_word[i]) lx_word[i] = '0;
        lx_too_long = 1'b0;
        lx_points = '0;
        lx_depth = '0;
        lx_off = '0;
        lx_line = 20'd1;
        lx_col = '0;
        org_off = '0;
        org_line = '0;
        org_col = '0;
        lx_span = '0;
    endfunction

    function automatic bit alpha_byte(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit digit_byte(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit space_byte(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit number_byte(logic [7:0] c);
        return digit_byte(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") ||
            c == "_" || c == "." || c == "x" || c == "X" || c == "o" || c == "O";
    endfunction

    // Lone operator code, or -1 when the byte starts no operator
    function automatic int lone_op(logic [7:0] c);
        case (c)
            "+": return 0;   "-": return 1;   "*": return 2;   "%": return 4;
            "\\": return 6;  "/": return 7;   "(": return 9;   ")": return 10;
            "=": return 11;  "!": return 13;  ">": return 15;  "<": return 17;
            "&": return 20;  "|": return 22;  "~": return 23;  "^": return 24;
            ",": return 25;  ".": return 26;  ";": return 27;  ":": return 28;
            "{": return 29;  "}": return 30;
            default: return -1;
        endcase
    endfunction

    function automatic bit can_pair(logic [7:0] c);
        return c == "*" || c == "%" || c == "/" || c == "=" || c == "!" ||
            c == ">" || c == "<" || c == "&" || c == "|";
    endfunction

    // Two-byte operator code; -2 opens a comment, -1 means no pair
    function automatic int joined_op(logic [7:0] h, logic [7:0] n);
        if (h == "*" && n == "*") return 2;
        if (h == "/" && n == "/") return -2;
        if (h == "&") return (n == "&") ? 19 : -1;
        if (h == "|") return (n == "|") ? 21 : -1;
        if (n != "=") return -1;
        case (h)
            "*": return 3;   "%": return 5;   "/": return 8;   "=": return 12;
            "!": return 14;  ">": return 16;  "<": return 18;
            default: return -1;
        endcase
    endfunction

    function automatic logic [5:0] word_code();
        string words [28] = '{"fn", "continue", "break", "let", "true", "false", "if",
            "else", "return", "for", "struct", "null", "extern", "cpp", "i8", "i16",
            "i32", "i64", "u8", "u16", "u32", "u64", "f32", "f64", "char", "bool",
            "str", "void"};
        bit same;
        if (lx_too_long) return K_IDENT;
        for (int i = 0; i < 28; i++)
        begin
            if (words[i].len() != lx_span) continue;
            same = 1'b1;
            for (int j = 0; j < words[i].len(); j++)
                if (words[i][j] != lx_word[j]) same = 1'b0;
            if (same) return K_FIRST_KW + 6'(i);
        end
        return K_IDENT;
    endfunction

    function automatic void put_token(logic [5:0] kind, logic [19:0] off, logic [19:0] line,
                                      logic [15:0] col, logic [15:0] len);
        token_rec_t t;
        if (step_tokens.size() >= 3) return;
        t.kind = kind; t.off = off; t.line = line; t.col = col; t.len = len; t.last = 1'b0;
        step_tokens = {step_tokens, t};
    endfunction

    function automatic void put_at_origin(logic [5:0] kind, logic [15:0] len);
        put_token(kind, org_off, org_line, org_col, len);
    endfunction

    function automatic void advance_position(logic [7:0] c);
        if (lx_off < OFF_MAX) lx_off++;
        if (c == CH_LF)
        begin
            if (lx_line < LINE_MAX) lx_line++;
            lx_col = '0;
        end
        else if (lx_col < COL_MAX)
            lx_col++;
    endfunction

    function automatic void grow_span();
        if (lx_span < SPAN_MAX) lx_span++;
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        int k;
        forever
        begin
            case (lx_mode)
                SCAN_HELD:
                begin
                    k = joined_op(lx_held, c);
                    lx_mode = SCAN_IDLE;
                    if (k == -2)
                    begin
                        lx_mode = SCAN_COMMENT;
                        advance_position(c);
                        return;
                    end
                    if (k >= 0)
                    begin
                        put_at_origin(6'(k), '0);
                        advance_position(c);
                        return;
                    end
                    // unpaired: emit the held operator, then rescan this byte
                    put_at_origin(6'(lone_op(lx_held)), '0);
                end
                SCAN_COMMENT:
                begin
                    if (c == CH_LF) lx_mode = SCAN_IDLE;
                    advance_position(c);
                    return;
                end
                SCAN_STRING:
                begin
                    if (c == CH_QUOTE || c == CH_LF)
                    begin
                        put_at_origin(K_STRING, lx_span);
                        lx_mode = SCAN_IDLE;
                    end
                    else
                        grow_span();
                    advance_position(c);
                    return;
                end
                SCAN_WORD:
                begin
                    if (alpha_byte(c) || digit_byte(c))
                    begin
                        if (lx_span < 8) lx_word[lx_span] = c;
                        else lx_too_long = 1'b1;
                        grow_span();
                        advance_position(c);
                        return;
                    end
                    if (word_code() == K_CPP)
                    begin
                        lx_mode = SCAN_CPP;
                        lx_depth = 8'd1;
                        lx_span = '0;
                        advance_position(c);
                        return;
                    end
                    put_at_origin(word_code(), lx_span);
                    lx_mode = SCAN_IDLE;
                end
                SCAN_NUMBER:
                begin
                    if (number_byte(c))
                    begin
                        grow_span();
                        advance_position(c);
                        if (c == CH_DOT)
                        begin
                            if (lx_points < 3) lx_points++;
                            if (lx_points > 1)
                            begin
                                put_at_origin(K_NUMBER, lx_span);
                                lx_mode = SCAN_IDLE;
                            end
                        end
                        return;
                    end
                    put_at_origin(K_NUMBER, lx_span);
                    lx_mode = SCAN_IDLE;
                end
                SCAN_CPP:
                begin
                    grow_span();
                    if (c == CH_LBRACE)
                    begin
                        if (lx_depth < BRACE_MAX) lx_depth++;
                    end
                    else if (c == CH_RBRACE)
                    begin
                        if (lx_depth > 0) lx_depth--;
                        if (lx_depth == 1) lx_depth = '0;
                    end
                    if (lx_depth == 0)
                    begin
                        put_at_origin(K_CPP, lx_span);
                        lx_mode = SCAN_IDLE;
                    end
                    advance_position(c);
                    return;
                end
                default:
                begin
                    lx_mode = SCAN_IDLE;
                    org_off = lx_off;
                    org_line = lx_line;
                    org_col = lx_col;
                    if (space_byte(c))
                        ;
                    else if (can_pair(c))
                    begin
                        lx_held = c;
                        lx_mode = SCAN_HELD;
                    end
                    else if (lone_op(c) >= 0)
                        put_at_origin(6'(lone_op(c)), '0);
                    else if (c == CH_QUOTE)
                    begin
                        lx_span = '0;
                        lx_mode = SCAN_STRING;
                    end
                    else if (alpha_byte(c))
                    begin
                        lx_word[0] = c;
                        lx_span = 16'd1;
                        lx_too_long = 1'b0;
                        lx_mode = SCAN_WORD;
                    end
                    else if (digit_byte(c))
                    begin
                        lx_span = 16'd1;
                        lx_points = '0;
                        lx_mode = SCAN_NUMBER;
                    end
                    else
                        put_at_origin(K_ERROR, '0);
                    advance_position(c);
                    return;
                end
            endcase
        end
    endfunction

    // Work out the tokens one byte causes and queue them
    function automatic int predict_tokens(logic [7:0] c, logic eot);
        int n;
        step_tokens.delete();
        scan_byte(c);
        if (eot)
        begin
            case (lx_mode)
                SCAN_HELD:   put_at_origin(6'(lone_op(lx_held)), '0);
                SCAN_STRING: put_at_origin(K_STRING, lx_span);
                SCAN_WORD:   put_at_origin(word_code() == K_CPP ? K_CPP : word_code(),
                                           word_code() == K_CPP ? 16'd0 : lx_span);
                SCAN_NUMBER: put_at_origin(K_NUMBER, lx_span);
                SCAN_CPP:    put_at_origin(K_CPP, lx_span);
                default: ;
            endcase
            put_token(K_END, lx_off, '0, '0, '0);
            lexer_clear();
        end
        n = step_tokens.size();
        if (n > 0) step_tokens[n - 1].last = 1'b1;
        foreach (step_tokens[i]) pending_tokens = {pending_tokens, step_tokens[i]};
        return n;
    endfunction

    // Output side: compare every accepted token with the oldest owed one
    always @(posedge clk)
    begin
        token_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            tokens_seen++;
            if (pending_tokens.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected token: exp none got kind=%0d off=%0d",
                        token_kind, start_offset);
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (token_kind !== want.kind || start_offset !== want.off ||
                    start_line !== want.line || start_column !== want.col ||
                    span_length !== want.len || last_of_run !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("token mismatch: exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                            want.kind, want.off, want.line, want.col, want.len, want.last,
                            token_kind, start_offset, start_line, start_column,
                            span_length, last_of_run);
                end
            end
        end
    end

    // Receiver stall pattern, with a long hold-off when requested
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_receiver)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Send one beat; hold it until accepted. Random idle gaps go before it.
    task automatic send_byte(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        end_of_text <= eot;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        void'(predict_tokens(c, eot));
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit with_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], with_end && (i == s.len() - 1));
    endtask

    task automatic drain_tokens();
        in_valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Directed rows: byte, end mark, whether to check, and the kind of the last token
    typedef struct {
        logic [7:0] c;
        logic       eot;
        logic       chk;
        logic [5:0] kind;
    } row_t;

    row_t plan [] = '{
        '{8'h00, 1'b0, 1'b1, K_ERROR},      // NUL is unknown
        '{8'hFF, 1'b0, 1'b1, K_ERROR},      // top byte is unknown
        '{8'h80, 1'b0, 1'b1, K_ERROR},
        '{"_",   1'b0, 1'b1, K_ERROR},      // leading underscore
        '{"*",   1'b0, 1'b0, '0},
        '{"*",   1'b0, 1'b1, K_STAR},       // star star collapses to one star
        '{"&",   1'b0, 1'b0, '0},
        '{"&",   1'b0, 1'b1, K_AND_AND},
        '{"|",   1'b0, 1'b0, '0},
        '{"|",   1'b0, 1'b1, K_OR_OR},
        '{"!",   1'b0, 1'b0, '0},
        '{"=",   1'b0, 1'b1, K_NOT_EQ},
        '{"<",   1'b0, 1'b0, '0},
        '{"=",   1'b0, 1'b1, K_LT_EQ},
        '{"\"",  1'b0, 1'b0, '0},
        '{"a",   1'b0, 1'b0, '0},
        '{8'h0A, 1'b0, 1'b1, K_STRING},     // string closed by newline
        '{"1",   1'b0, 1'b0, '0},
        '{".",   1'b0, 1'b0, '0},
        '{".",   1'b0, 1'b1, K_NUMBER},     // second point ends the number
        '{"/",   1'b0, 1'b0, '0},
        '{"/",   1'b0, 1'b0, '0},           // comment, nothing comes out
        '{8'h0A, 1'b0, 1'b0, '0},
        '{"q",   1'b1, 1'b1, K_END}         // word flushed, then end
    };

    function automatic string random_word();
        string kw [] = '{"fn", "continue", "cpp", "u6", "u16", "void", "let", "if",
                         "else", "return", "struct", "i64", "char", "bool", "x", "identifier9"};
        return kw[$urandom_range(kw.size() - 1)];
    endfunction

    function automatic string random_piece();
        string s;
        string ops [] = '{"+", "-", "*", "**", "*=", "%", "%=", "\\", "/", "/=", "(", ")",
            "=", "==", "!", "!=", ">", ">=", "<", "<=", "&&", "&", "||", "|", "~", "^",
            ",", ".", ";", ":", "{", "}"};
        case ($urandom_range(9))
            0, 1: s = random_word();
            2:    s = ops[$urandom_range(ops.size() - 1)];
            3:    s = $sformatf("%0d", $urandom_range(99999));
            4:    s = "0x1f.3.";
            5:    s = "\"ab c\"";
            6:    s = "// note\n";
            7:    s = "cpp {a{b}c}";
            8:    s = "\n";
            default:
            begin
                s = " ";
                s[0] = 8'($urandom_range(255));
                if (s[0] == 0) s[0] = 8'h01;
            end
        endcase
        return s;
    endfunction

    task automatic run_random_text();
        string piece;
        int n;
        n = $urandom_range(4, 2);
        for (int i = 0; i < n; i++)
        begin
            piece = random_piece();
            send_text(piece, 1'b0);
            if ($urandom_range(2) != 0) send_byte(" ", 1'b0);
        end
        // mostly a clean ending, sometimes end mid-token on a random byte
        if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)), 1'b1);
        else send_byte(";", 1'b1);
    endtask

    initial
    begin
        int n;
        cycle_count = 0;
        mismatch_count = 0;
        tokens_seen = 0;
        bytes_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_receiver = 1'b0;
        in_valid = 1'b0;
        ch = '0;
        end_of_text = 1'b0;
        lexer_clear();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: rows with a kind given check it against the predictor too
        foreach (plan[i])
        begin
            send_byte(plan[i].c, plan[i].eot);
            if (plan[i].chk &&
                (step_tokens.size() == 0 ||
                 step_tokens[step_tokens.size() - 1].kind != plan[i].kind))
            begin
                mismatch_count++;
                $display("directed row %0d: predictor disagrees with table", i);
            end
        end
        drain_tokens();

        // Special texts: cpp block, end inside a string, long word, open cpp block
        send_text("cpp {x{y}z} void u6 u16", 1'b1);
        send_text("\"open str", 1'b1);
        send_text("abcdefghij", 1'b1);
        send_text("cpp {{{", 1'b1);
        drain_tokens();

        // Random phases with different idle patterns
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            n = bytes_sent;
            while (bytes_sent - n < 8) run_random_text();
        end

        // Long receiver hold-off while bytes keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
        begin
            hold_receiver = 1'b1;
            repeat (STALL_HOLD_CYCLES) @(posedge clk);
            hold_receiver = 1'b0;
        end
        begin
            send_text("a+b*c;d,e(f)", 1'b1);
        end
        join

        drain_tokens();
        repeat (20) @(posedge clk);
        if (pending_tokens.size() != 0) mismatch_count++;

        $display("covered %0d bytes and %0d tokens over four idle patterns and a long stall",
            bytes_sent, tokens_seen);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/stt_pkg.sv
sv/stt_queue.sv
sv/stt_front.sv
sv/stt_back.sv
sv/source_text_tokenizer.sv
tb/source_text_tokenizer_test.sv
